// File: hw/rtl/stgc_pkg.sv
// Shared types and constants for the segment table ground collision unit.
// Used by the controller, the datapath and the top level.
`default_nettype none
package stgc_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = 7;
  localparam int SEG_W        = 64;
  localparam int DIV_STEPS    = 34;
  localparam int STEP_W       = 6;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_GROUND = 2'd1;
  localparam logic [1:0] OP_WALL   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RD,
    ST_ORI,
    ST_DRAIN,
    ST_CHECK,
    ST_MUL,
    ST_DSET,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 accept;
    logic [SEG_IDX_W-1:0] rd_addr;
    logic                 ori_go;
    logic [1:0]           ori_sel;
    logic                 hit_ground;
    logic                 hit_wall;
    logic                 mul_go;
    logic                 div_load;
    logic                 div_step;
    logic                 fin;
  } cmd_t;

  typedef struct packed {
    logic zero_motion;
    logic hit;
    logic vertical;
  } status_t;

endpackage
`default_nettype wire

// File: hw/rtl/stgc_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module stgc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/stgc_ctrl.sv
// Controller: sequences loads, the segment walk and the divide.
// Depends on stgc_pkg.
`default_nettype none
module stgc_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [1:0]                  in_operation,
  input  wire logic                        cfg_valid,
  input  wire logic [stgc_pkg::CNT_W-1:0]  cfg_segment_count,
  input  wire stgc_pkg::status_t           status,
  output logic                             busy,
  output logic                             cfg_ready,
  output logic                             out_valid,
  output stgc_pkg::cmd_t                   cmd
);
  import stgc_pkg::*;

  localparam logic [CNT_W-1:0] SEG_MAX = CNT_W'(MAX_SEGMENTS);

  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [SEG_IDX_W-1:0] seg_r, seg_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     seg_limit;
  logic                 last_seg;
  logic                 accept;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign seg_limit = (count_r > SEG_MAX) ? SEG_MAX : count_r;
  assign last_seg  = ((CNT_W'(seg_r) + CNT_W'(1)) == seg_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      seg_r   <= '0;
      op_r    <= OP_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      seg_r   <= seg_nxt;
      op_r    <= op_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_segment_count;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_GROUND || in_operation == OP_WALL) begin
            state_nxt = ST_SETUP;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SETUP: begin
        if (status.zero_motion || seg_limit == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:    state_nxt = ST_ORI;
      ST_ORI: begin
        if (cnt_r == STEP_W'(3)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (status.hit) begin
          if (op_r == OP_GROUND && !status.vertical) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_OUT;
          end
        end else if (last_seg) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_MUL:   state_nxt = ST_DSET;
      ST_DSET:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:   state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // counters and latched operation
  always_comb begin
    cnt_nxt = cnt_r;
    seg_nxt = seg_r;
    op_nxt  = op_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt = in_operation;
        end
        seg_nxt = '0;
      end
      ST_RD:    cnt_nxt = '0;
      ST_ORI:   cnt_nxt = cnt_r + STEP_W'(1);
      ST_CHECK: begin
        if (!status.hit && !last_seg) begin
          seg_nxt = seg_r + SEG_IDX_W'(1);
        end
      end
      ST_DSET:  cnt_nxt = '0;
      ST_DIV:   cnt_nxt = cnt_r + STEP_W'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    cmd.rd_addr    = seg_r;
    cmd.ori_sel    = cnt_r[1:0];
    out_valid      = 1'b0;
    case (state_r)
      ST_IDLE:  cmd.accept = accept;
      ST_ORI:   cmd.ori_go = 1'b1;
      ST_CHECK: begin
        cmd.hit_ground = status.hit & (op_r == OP_GROUND);
        cmd.hit_wall   = status.hit & (op_r == OP_WALL);
      end
      ST_MUL:   cmd.mul_go   = 1'b1;
      ST_DSET:  cmd.div_load = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FIN:   cmd.fin      = 1'b1;
      ST_OUT:   out_valid    = 1'b1;
      default:  cmd.accept   = 1'b0;
    endcase
  end

  a_out_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> (state_r == ST_IDLE))
    else $error("result strobe longer than one cycle");

  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (CNT_W'(seg_r) < seg_limit))
    else $error("segment walk beyond count");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < STEP_W'(DIV_STEPS)))
    else $error("divide step count overrun");

endmodule
`default_nettype wire

// File: hw/rtl/stgc_dp.sv
// Datapath: segment table, orientation unit, serial divider, result registers.
// Depends on stgc_pkg and stgc_ram.
`default_nettype none
module stgc_dp (
  input  wire logic                 clk,
  input  wire stgc_pkg::cmd_t       cmd,
  input  wire logic [1:0]           in_operation,
  input  wire logic [5:0]           in_seg_index,
  input  wire logic signed [15:0]   in_seg_src_x,
  input  wire logic signed [15:0]   in_seg_src_y,
  input  wire logic signed [15:0]   in_seg_dst_x,
  input  wire logic signed [15:0]   in_seg_dst_y,
  input  wire logic signed [15:0]   in_pos_x,
  input  wire logic signed [15:0]   in_pos_y,
  input  wire logic signed [10:0]   in_vel_x,
  input  wire logic signed [10:0]   in_vel_y,
  input  wire logic [9:0]           in_body_size,
  output stgc_pkg::status_t         status,
  output logic                      out_grounded,
  output logic signed [15:0]        out_new_pos_y,
  output logic signed [10:0]        out_new_vel_x,
  output logic signed [10:0]        out_new_vel_y
);
  import stgc_pkg::*;

  logic [SEG_W-1:0] seg_word;
  logic             ram_we;

  assign ram_we = cmd.accept & (in_operation == OP_LOAD);

  stgc_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_seg_index[SEG_IDX_W-1:0]),
    .wdata ({in_seg_dst_y, in_seg_dst_x, in_seg_src_y, in_seg_src_x}),
    .raddr (cmd.rd_addr),
    .rdata (seg_word)
  );

  // query word
  logic signed [15:0] px_r, py_r;
  logic signed [10:0] vx_r, vy_r;
  logic [9:0]         size_r;
  logic               ground_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r     <= in_pos_x;
      py_r     <= in_pos_y;
      vx_r     <= in_vel_x;
      vy_r     <= in_vel_y;
      size_r   <= in_body_size;
      ground_r <= (in_operation == OP_GROUND);
    end
  end

  logic signed [17:0] ex, ey, sx, sy, dx, dy, mx, my;
  logic signed [17:0] dy_off;

  assign dy_off = 18'(vy_r) + (ground_r ? 18'(signed'({1'b0, size_r})) : 18'sd0);
  assign mx     = 18'(px_r);
  assign my     = 18'(py_r);
  assign ex     = mx + 18'(vx_r);
  assign ey     = my + dy_off;
  assign sx     = 18'(signed'(seg_word[15:0]));
  assign sy     = 18'(signed'(seg_word[31:16]));
  assign dx     = 18'(signed'(seg_word[47:32]));
  assign dy     = 18'(signed'(seg_word[63:48]));

  assign status.zero_motion = (vx_r == '0) && (dy_off == '0);
  assign status.vertical    = (dx == sx);

  // orientation: (bx-ax)*(cy-ay) - (by-ay)*(cx-ax), two products per issue
  logic signed [17:0] ax, ay, bx, by, cx, cy;
  logic signed [18:0] d_bax, d_cay, d_bay, d_cax;
  logic signed [37:0] prod_a_r, prod_b_r;
  logic               go_d_r;
  logic [1:0]         sel_d_r;
  logic signed [38:0] ori;
  logic [3:0]         neg_r, zero_r;

  always_comb begin
    case (cmd.ori_sel)
      2'd0: begin ax = sx; ay = sy; bx = dx; by = dy; cx = mx; cy = my; end
      2'd1: begin ax = sx; ay = sy; bx = dx; by = dy; cx = ex; cy = ey; end
      2'd2: begin ax = mx; ay = my; bx = ex; by = ey; cx = sx; cy = sy; end
      default: begin ax = mx; ay = my; bx = ex; by = ey; cx = dx; cy = dy; end
    endcase
  end

  assign d_bax = 19'(bx) - 19'(ax);
  assign d_cay = 19'(cy) - 19'(ay);
  assign d_bay = 19'(by) - 19'(ay);
  assign d_cax = 19'(cx) - 19'(ax);
  assign ori   = 39'(prod_a_r) - 39'(prod_b_r);

  always_ff @(posedge clk) begin
    go_d_r   <= cmd.ori_go;
    sel_d_r  <= cmd.ori_sel;
    prod_a_r <= 38'(d_bax) * 38'(d_cay);
    prod_b_r <= 38'(d_bay) * 38'(d_cax);
    if (go_d_r) begin
      neg_r[sel_d_r]  <= ori[38];
      zero_r[sel_d_r] <= (ori == '0);
    end
  end

  assign status.hit = (zero_r[0] | zero_r[1] | (neg_r[0] ^ neg_r[1]))
                    & (zero_r[2] | zero_r[3] | (neg_r[2] ^ neg_r[3]));

  // interpolation: (dy-sy)*(px-sx) / (dx-sx), restoring divide on magnitudes
  logic signed [33:0] num_r;
  logic signed [16:0] den_r;
  logic [33:0]        quo_r;
  logic [17:0]        rem_r;
  logic [16:0]        dmag_r;
  logic               qneg_r;
  logic [17:0]        shifted;
  logic [18:0]        trial;
  logic signed [34:0] qs;
  logic signed [36:0] y_full;
  logic signed [15:0] y_sat;

  assign shifted = {rem_r[16:0], quo_r[33]};
  assign trial   = {1'b0, shifted} - {2'b0, dmag_r};
  assign qs      = qneg_r ? -35'(signed'({1'b0, quo_r})) : 35'(signed'({1'b0, quo_r}));
  assign y_full  = 37'(qs) + 37'(sy) - 37'(signed'({1'b0, size_r}));

  always_comb begin
    if (y_full > 37'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y_full < -37'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      num_r <= 34'(17'(dy) - 17'(sy)) * 34'(17'(mx) - 17'(sx));
      den_r <= 17'(dx) - 17'(sx);
    end
    if (cmd.div_load) begin
      quo_r  <= num_r[33] ? 34'(-num_r) : 34'(num_r);
      rem_r  <= '0;
      dmag_r <= den_r[16] ? 17'(-den_r) : 17'(den_r);
      qneg_r <= num_r[33] ^ den_r[16];
    end else if (cmd.div_step) begin
      if (!trial[18]) begin
        rem_r <= trial[17:0];
        quo_r <= {quo_r[32:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[32:0], 1'b0};
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_grounded  <= 1'b0;
      out_new_pos_y <= in_pos_y;
      out_new_vel_x <= in_vel_x;
      out_new_vel_y <= in_vel_y;
    end else begin
      if (cmd.hit_ground) begin
        out_grounded  <= 1'b1;
        out_new_vel_y <= '0;
      end
      if (cmd.hit_wall) begin
        out_new_vel_x <= '0;
      end
      if (cmd.fin) begin
        out_new_pos_y <= y_sat;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/segment_table_ground_collision_unit.sv
// Top level of the segment table ground collision unit.
// Depends on stgc_pkg, stgc_ctrl, stgc_dp (which holds stgc_ram).
`default_nettype none
// Take a word when start is high and busy is low; exactly one result word
// follows, shown for one cycle with out_valid high, and the receiver cannot
// stall it. A load or an unused code goes straight to its result word. A
// query walks the segments up to the first crossing, each tested by one shared
// orientation unit that evaluates one sign test per cycle on the table's
// single read port; a ground hit on a non-vertical segment also runs the
// one-bit-per-cycle interpolation divider. segment_count is written through
// the cfg port while busy is low; table entries that were never loaded must
// not be walked.
module segment_table_ground_collision_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_operation,
  input  wire logic [5:0]           in_seg_index,
  input  wire logic signed [15:0]   in_seg_src_x,
  input  wire logic signed [15:0]   in_seg_src_y,
  input  wire logic signed [15:0]   in_seg_dst_x,
  input  wire logic signed [15:0]   in_seg_dst_y,
  input  wire logic signed [15:0]   in_pos_x,
  input  wire logic signed [15:0]   in_pos_y,
  input  wire logic signed [10:0]   in_vel_x,
  input  wire logic signed [10:0]   in_vel_y,
  input  wire logic [9:0]           in_body_size,
  output logic                      out_valid,
  output logic                      out_grounded,
  output logic signed [15:0]        out_new_pos_y,
  output logic signed [10:0]        out_new_vel_x,
  output logic signed [10:0]        out_new_vel_y,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [6:0]           cfg_segment_count
);
  import stgc_pkg::*;

  cmd_t    cmd;
  status_t status;

  stgc_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_operation      (in_operation),
    .cfg_valid         (cfg_valid),
    .cfg_segment_count (cfg_segment_count),
    .status            (status),
    .busy              (busy),
    .cfg_ready         (cfg_ready),
    .out_valid         (out_valid),
    .cmd               (cmd)
  );

  stgc_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .in_operation  (in_operation),
    .in_seg_index  (in_seg_index),
    .in_seg_src_x  (in_seg_src_x),
    .in_seg_src_y  (in_seg_src_y),
    .in_seg_dst_x  (in_seg_dst_x),
    .in_seg_dst_y  (in_seg_dst_y),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_body_size  (in_body_size),
    .status        (status),
    .out_grounded  (out_grounded),
    .out_new_pos_y (out_new_pos_y),
    .out_new_vel_x (out_new_vel_x),
    .out_new_vel_y (out_new_vel_y)
  );

endmodule
`default_nettype wire

// File: sim/segment_table_ground_collision_unit_test.sv
// Self-checking testbench for the segment table ground collision unit.
// Depends on stgc_pkg and the unit's RTL; predicts every result word in place.
`default_nettype none
module segment_table_ground_collision_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stgc_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     SETTLE      = 600;

  typedef struct {
    logic [1:0]          operation;
    logic [5:0]          seg_index;
    logic signed [15:0]  src_x, src_y, dst_x, dst_y;
    logic signed [15:0]  pos_x, pos_y;
    logic signed [10:0]  vel_x, vel_y;
    logic [9:0]          body_size;
  } motion_word_t;

  typedef struct {
    logic               grounded;
    logic signed [15:0] pos_y;
    logic signed [10:0] vel_x, vel_y;
  } landing_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic [5:0] in_seg_index = '0;
  logic signed [15:0] in_seg_src_x = '0, in_seg_src_y = '0;
  logic signed [15:0] in_seg_dst_x = '0, in_seg_dst_y = '0;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0;
  logic signed [10:0] in_vel_x = '0, in_vel_y = '0;
  logic [9:0] in_body_size = '0;
  logic out_valid, out_grounded;
  logic signed [15:0] out_new_pos_y;
  logic signed [10:0] out_new_vel_x, out_new_vel_y;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [6:0] cfg_segment_count = '0;

  segment_table_ground_collision_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_seg_index(in_seg_index),
    .in_seg_src_x(in_seg_src_x), .in_seg_src_y(in_seg_src_y),
    .in_seg_dst_x(in_seg_dst_x), .in_seg_dst_y(in_seg_dst_y),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_body_size(in_body_size),
    .out_valid(out_valid), .out_grounded(out_grounded),
    .out_new_pos_y(out_new_pos_y), .out_new_vel_x(out_new_vel_x),
    .out_new_vel_y(out_new_vel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_segment_count(cfg_segment_count)
  );

  motion_word_t pending_words[$];
  landing_t     expected_landings[$];
  logic [63:0]  seg_mem [MAX_SEGMENTS];
  logic [6:0]   walk_count = '0;
  bit           failed = 0;
  longint       cycle_count = 0;
  int           burst_left = 1;
  int           gap_left = 0;
  bit           took, go;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int sign_of(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint orientation(longint ax, longint ay, longint bx,
                                         longint by, longint cx, longint cy);
    return (ax * by + bx * cy + cx * ay) - (ay * bx + by * cx + cy * ax);
  endfunction

  function automatic bit motion_crosses(longint sx, longint sy, longint dx,
                                        longint dy, longint x0, longint y0,
                                        longint x1, longint y1);
    int a, b, c, d;
    if (x0 == x1 && y0 == y1) return 0;
    a = sign_of(orientation(sx, sy, dx, dy, x0, y0));
    b = sign_of(orientation(sx, sy, dx, dy, x1, y1));
    c = sign_of(orientation(x0, y0, x1, y1, sx, sy));
    d = sign_of(orientation(x0, y0, x1, y1, dx, dy));
    return (a * b) <= 0 && (c * d) <= 0;
  endfunction

  // Apply one accepted word to the table copy and work out its landing.
  function automatic landing_t resolve_motion(motion_word_t w);
    landing_t r;
    longint px, py, ex, ey, sz, sx, sy, dx, dy, y;
    int n;
    px = w.pos_x; py = w.pos_y; sz = w.body_size;
    r.grounded = 1'b0; r.pos_y = w.pos_y; r.vel_x = w.vel_x; r.vel_y = w.vel_y;
    if (w.operation == OP_LOAD) begin
      seg_mem[w.seg_index] = {w.dst_y, w.dst_x, w.src_y, w.src_x};
    end else if (w.operation == OP_GROUND || w.operation == OP_WALL) begin
      n = (walk_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(walk_count);
      ex = px + w.vel_x;
      ey = py + w.vel_y + ((w.operation == OP_GROUND) ? sz : 0);
      for (int i = 0; i < n; i++) begin
        sx = $signed(seg_mem[i][15:0]);  sy = $signed(seg_mem[i][31:16]);
        dx = $signed(seg_mem[i][47:32]); dy = $signed(seg_mem[i][63:48]);
        if (motion_crosses(sx, sy, dx, dy, px, py, ex, ey)) begin
          if (w.operation == OP_GROUND) begin
            r.grounded = 1'b1;
            r.vel_y = '0;
            if (dx != sx) begin
              y = (dy - sy) * (px - sx) / (dx - sx) + sy - sz;
              if (y > 32767) y = 32767;
              if (y < -32768) y = -32768;
              r.pos_y = y[15:0];
            end
          end else begin
            r.vel_x = '0;
          end
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic motion_word_t noise_word();
    motion_word_t w;
    w.operation = 2'($urandom_range(0, 3));
    w.seg_index = 6'($urandom); w.src_x = 16'($urandom); w.src_y = 16'($urandom);
    w.dst_x = 16'($urandom); w.dst_y = 16'($urandom); w.pos_x = 16'($urandom);
    w.pos_y = 16'($urandom); w.vel_x = 11'($urandom); w.vel_y = 11'($urandom);
    w.body_size = 10'($urandom);
    return w;
  endfunction

  function automatic motion_word_t load_word(int idx);
    motion_word_t w;
    longint cx, cy, lx, ly;
    w = noise_word();
    w.operation = OP_LOAD;
    w.seg_index = 6'(idx);
    if ($urandom_range(0, 5) != 0) begin
      cx = longint'($urandom_range(0, 40000)) - 20000;
      cy = longint'($urandom_range(0, 40000)) - 20000;
      lx = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(0, 4000)) - 2000;
      ly = longint'($urandom_range(0, 1000)) - 500;
      w.src_x = 16'(cx); w.src_y = 16'(cy);
      w.dst_x = 16'(cx + lx); w.dst_y = 16'(cy + ly);
    end
    return w;
  endfunction

  // Aim a query at a stored segment so that most queries actually land.
  function automatic motion_word_t aimed_word(logic [1:0] op, int n);
    motion_word_t w;
    longint sx, sy, dx, dy, x, y, t, k, v;
    int i;
    w = noise_word();
    w.operation = op;
    if (n == 0) return w;
    i = int'($urandom_range(0, n - 1));
    sx = $signed(seg_mem[i][15:0]);  sy = $signed(seg_mem[i][31:16]);
    dx = $signed(seg_mem[i][47:32]); dy = $signed(seg_mem[i][63:48]);
    t = longint'($urandom_range(0, 16));
    x = sx + (dx - sx) * t / 16;
    y = sy + (dy - sy) * t / 16;
    v = longint'($urandom_range(1, 1023));
    k = longint'($urandom_range(0, 1023)) % (v + 1);
    if ($urandom_range(0, 3) == 0) w.body_size = '0;
    if (op == OP_GROUND) begin
      w.pos_x = clamp16(x);
      w.pos_y = clamp16(y - w.body_size - k);
      w.vel_x = 11'(longint'($urandom_range(0, 6)) - 3);
      w.vel_y = 11'(v);
    end else begin
      w.pos_x = clamp16(x - k);
      w.pos_y = clamp16(y);
      w.vel_x = 11'(v);
      w.vel_y = 11'(longint'($urandom_range(0, 6)) - 3);
    end
    return w;
  endfunction

  function automatic motion_word_t query(logic [1:0] op, int px, int py, int vx,
                                         int vy, int sz);
    motion_word_t w;
    w = noise_word();
    w.operation = op; w.pos_x = 16'(px); w.pos_y = 16'(py);
    w.vel_x = 11'(vx); w.vel_y = 11'(vy); w.body_size = 10'(sz);
    return w;
  endfunction

  function automatic motion_word_t fixed_load(int idx, int sx, int sy, int dx, int dy);
    motion_word_t w;
    w = noise_word();
    w.operation = OP_LOAD; w.seg_index = 6'(idx);
    w.src_x = 16'(sx); w.src_y = 16'(sy); w.dst_x = 16'(dx); w.dst_y = 16'(dy);
    return w;
  endfunction

  // Driver: hold start until the word is taken, then advance in bursts.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      took = start && !busy;
      if (took) begin
        expected_landings.push_back(resolve_motion(pending_words[0]));
        void'(pending_words.pop_front());
      end
      if (!start || took) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          go = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end
        start <= go;
        if (go) begin
          in_operation <= pending_words[0].operation;
          in_seg_index <= pending_words[0].seg_index;
          in_seg_src_x <= pending_words[0].src_x;
          in_seg_src_y <= pending_words[0].src_y;
          in_seg_dst_x <= pending_words[0].dst_x;
          in_seg_dst_y <= pending_words[0].dst_y;
          in_pos_x <= pending_words[0].pos_x;
          in_pos_y <= pending_words[0].pos_y;
          in_vel_x <= pending_words[0].vel_x;
          in_vel_y <= pending_words[0].vel_y;
          in_body_size <= pending_words[0].body_size;
        end
      end
    end
  end

  // Monitor: every result word is checked against the oldest landing.
  always @(posedge clk) begin
    landing_t e;
    if (rst_n && out_valid) begin
      if (expected_landings.size() == 0) begin
        $error("unexpected result word");
        failed = 1;
      end else begin
        e = expected_landings.pop_front();
        if (out_grounded !== e.grounded) begin
          $error("grounded expected %0d actual %0d", e.grounded, out_grounded);
          failed = 1;
        end
        if (out_new_pos_y !== e.pos_y) begin
          $error("new_pos_y expected %0d actual %0d", e.pos_y, out_new_pos_y);
          failed = 1;
        end
        if (out_new_vel_x !== e.vel_x) begin
          $error("new_vel_x expected %0d actual %0d", e.vel_x, out_new_vel_x);
          failed = 1;
        end
        if (out_new_vel_y !== e.vel_y) begin
          $error("new_vel_y expected %0d actual %0d", e.vel_y, out_new_vel_y);
          failed = 1;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || expected_landings.size() != 0 || start || busy);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_count(int value);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_segment_count <= 7'(value);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 0;
    walk_count = 7'(value);
  endtask

  initial begin
    int counts[8];
    int r, n;
    counts = '{64, 127, 1, 0, 0, 0, 0, 65};
    for (int i = 4; i < 7; i++) counts[i] = $urandom_range(2, 64);
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // Directed: flat floor, wall, two long diagonals, bottom floor, a point
    pending_words.push_back(fixed_load(0, -100, 0, 100, 0));
    pending_words.push_back(fixed_load(1, 50, -100, 50, 100));
    pending_words.push_back(fixed_load(2, -32768, -32768, 32767, 32767));
    pending_words.push_back(fixed_load(3, -20, -32768, 20, -32768));
    pending_words.push_back(fixed_load(63, -1, -1, -1, -1));
    pending_words.push_back(fixed_load(62, -32768, 32767, 32767, -32768));
    drain();
    write_count(4);
    pending_words.push_back(query(OP_GROUND, 0, -50, 0, 60, 10));
    pending_words.push_back(query(OP_GROUND, 30, -50, 0, 60, 0));
    pending_words.push_back(query(OP_WALL, 40, 50, 20, 0, 0));
    pending_words.push_back(query(OP_GROUND, 45, 50, 10, 0, 0));
    pending_words.push_back(query(OP_WALL, 40, 50, 0, 0, 7));
    pending_words.push_back(query(OP_GROUND, 0, -32768, 0, 1, 1023));
    pending_words.push_back(query(OP_GROUND, 32767, 32767, 1023, 1023, 1023));
    pending_words.push_back(query(OP_WALL, -32768, -32768, -1024, -1024, 0));
    pending_words.push_back(query(OP_GROUND, -32768, 32767, -1024, -1024, 1023));
    pending_words.push_back(query(2'd3, 0, -50, 0, 60, 10));
    pending_words.push_back(query(OP_WALL, 0, -50, 0, 60, 10));
    drain();

    // Fill the rest of the table while only the first entries are walked
    for (int i = 4; i < MAX_SEGMENTS; i++) begin
      pending_words.push_back(load_word(i));
      if ($urandom_range(0, 3) == 0) pending_words.push_back(aimed_word(OP_GROUND, 4));
    end
    drain();

    foreach (counts[p]) begin
      write_count(counts[p]);
      n = (counts[p] > MAX_SEGMENTS) ? MAX_SEGMENTS : counts[p];
      for (int i = 0; i < 200; i++) begin
        r = $urandom_range(0, 99);
        if (r < 12) pending_words.push_back(load_word($urandom_range(0, 63)));
        else if (r < 22) pending_words.push_back(noise_word());
        else if (r < 62) pending_words.push_back(aimed_word(OP_GROUND, n));
        else pending_words.push_back(aimed_word(OP_WALL, n));
        // table copy is updated only on acceptance; keep aiming close behind
        if (pending_words.size() > 8) begin
          while (pending_words.size() > 4) @(negedge clk);
        end
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (!failed && expected_landings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
